// ===== design/rtccal_pkg.sv =====
// Package: widths, constants, stage payload types and helpers for the day-count calendar decoder.
`default_nettype none
package rtccal_pkg;

    localparam int DAY_W  = 16;
    localparam int DAYS_W = 17;
    localparam int HOUR_W = 5;
    localparam int MIN_W  = 6;
    localparam int SEC_W  = 6;
    localparam int WDAY_W = 3;
    localparam int YEAR_W = 8;
    localparam int DOY_W  = 9;
    localparam int MON_W  = 4;
    localparam int DOM_W  = 5;
    localparam int YOFF_W = 8;
    localparam int LEFT_W = 18;
    localparam int PROD_W = 33;
    localparam int NSTAGE = 5;

    localparam int SEC_PER_MIN   = 60;
    localparam int MIN_PER_HOUR  = 60;
    localparam int HOUR_PER_DAY  = 24;
    localparam int EPOCH_WDAY    = 4;
    localparam int DAYS_PER_YEAR = 365;
    localparam int YEAR_RECIP    = 45965;
    localparam int YEAR_SHIFT    = 24;
    localparam int EPOCH_YEAR    = 70;
    localparam int Q_2100        = 131;
    localparam int YOFF_2100     = 130;
    localparam int MONTHS        = 12;
    localparam int MAR_IDX       = 2;

    localparam logic [DOY_W-1:0] MONTH_START [MONTHS] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
    } t_tod;

    typedef struct packed {
        logic [DAYS_W-1:0] days;
        t_tod              tod;
    } t_s1;

    typedef struct packed {
        logic [DAYS_W-1:0] days;
        logic [YOFF_W-1:0] q;
        logic [WDAY_W-1:0] wday;
        t_tod              tod;
    } t_s2;

    typedef struct packed {
        logic signed [LEFT_W-1:0] left;
        logic [YOFF_W-1:0]        q;
        logic [WDAY_W-1:0]        wday;
        t_tod                     tod;
    } t_s3;

    typedef struct packed {
        logic [DOY_W-1:0]  left;
        logic [YOFF_W-1:0] yoff;
        logic              leap;
        logic [WDAY_W-1:0] wday;
        t_tod              tod;
    } t_s4;

    typedef struct packed {
        t_tod              tod;
        logic [WDAY_W-1:0] wday;
        logic [YEAR_W-1:0] year;
        logic [DOY_W-1:0]  doy;
        logic [MON_W-1:0]  month;
        logic [DOM_W-1:0]  dom;
    } t_res;

    // (days + epoch weekday) mod 7 by folding octal digits
    function automatic logic [WDAY_W-1:0] mod7(input logic [DAYS_W-1:0] d);
        logic [DAYS_W:0] x;
        logic [5:0]      s1;
        logic [3:0]      s2;
        logic [3:0]      s3;
        x  = {1'b0, d} + (DAYS_W+1)'(EPOCH_WDAY);
        s1 = '0;
        for (int i = 0; i < (DAYS_W + 1) / 3; i++) begin
            s1 = s1 + {3'b000, x[3*i +: 3]};
        end
        s2 = {1'b0, s1[5:3]} + {1'b0, s1[2:0]};
        s3 = {3'b000, s2[3]} + {1'b0, s2[2:0]};
        if (s3 >= 4'd7) begin
            s3 = s3 - 4'd7;
        end
        return s3[WDAY_W-1:0];
    endfunction

    function automatic logic [DOY_W-1:0] month_start(input logic [MON_W-1:0] m,
                                                     input logic leap);
        logic [DOY_W-1:0] s;
        s = (m < MON_W'(MONTHS)) ? MONTH_START[m] : '0;
        if (leap && m >= MON_W'(MAR_IDX)) begin
            s = s + DOY_W'(1);
        end
        return s;
    endfunction

endpackage
`default_nettype wire

// ===== design/rtccal_if.sv =====
// Interfaces: input reading channel and calendar result channel.
`default_nettype none
interface rtccal_in_if;
    logic                          valid;
    logic                          ready;
    logic [rtccal_pkg::DAY_W-1:0]  day_count;
    logic [rtccal_pkg::HOUR_W-1:0] hour_field;
    logic [rtccal_pkg::MIN_W-1:0]  minute_field;
    logic [rtccal_pkg::SEC_W-1:0]  second_field;

    modport source (output valid, day_count, hour_field, minute_field, second_field,
                    input ready);
    modport sink (input valid, day_count, hour_field, minute_field, second_field,
                  output ready);
endinterface

interface rtccal_out_if;
    logic                          valid;
    logic                          ready;
    logic [rtccal_pkg::HOUR_W-1:0] hour_out;
    logic [rtccal_pkg::MIN_W-1:0]  minute_out;
    logic [rtccal_pkg::SEC_W-1:0]  second_out;
    logic [rtccal_pkg::WDAY_W-1:0] weekday;
    logic [rtccal_pkg::YEAR_W-1:0] year_since_1900;
    logic [rtccal_pkg::DOY_W-1:0]  day_of_year;
    logic [rtccal_pkg::MON_W-1:0]  month_index;
    logic [rtccal_pkg::DOM_W-1:0]  day_of_month;

    modport source (output valid, hour_out, minute_out, second_out, weekday,
                    year_since_1900, day_of_year, month_index, day_of_month,
                    input ready);
    modport sink (input valid, hour_out, minute_out, second_out, weekday,
                  year_since_1900, day_of_year, month_index, day_of_month,
                  output ready);
endinterface
`default_nettype wire

// ===== design/rtccal_time.sv =====
// Stage 1: normalize second, minute and hour fields and carry into the day count.
`default_nettype none
module rtccal_time (
    input  wire logic                         i_clk,
    input  wire logic                         i_en,
    input  wire logic [rtccal_pkg::DAY_W-1:0]  i_day_count,
    input  wire logic [rtccal_pkg::HOUR_W-1:0] i_hour,
    input  wire logic [rtccal_pkg::MIN_W-1:0]  i_minute,
    input  wire logic [rtccal_pkg::SEC_W-1:0]  i_second,
    output rtccal_pkg::t_s1                    o_s1
);
    rtccal_pkg::t_s1 r_s1;
    rtccal_pkg::t_s1 n_s1;

    logic                            c_sec;
    logic                            c_min;
    logic                            c_hour;
    logic [rtccal_pkg::MIN_W:0]      min_sum;
    logic [rtccal_pkg::HOUR_W:0]     hour_sum;

    always_comb begin
        c_sec = i_second >= rtccal_pkg::SEC_W'(rtccal_pkg::SEC_PER_MIN);
        n_s1.tod.second = c_sec ? i_second - rtccal_pkg::SEC_W'(rtccal_pkg::SEC_PER_MIN)
                                : i_second;
        min_sum = {1'b0, i_minute} + (rtccal_pkg::MIN_W+1)'(c_sec);
        c_min   = min_sum >= (rtccal_pkg::MIN_W+1)'(rtccal_pkg::MIN_PER_HOUR);
        n_s1.tod.minute = c_min
            ? rtccal_pkg::MIN_W'(min_sum - (rtccal_pkg::MIN_W+1)'(rtccal_pkg::MIN_PER_HOUR))
            : min_sum[rtccal_pkg::MIN_W-1:0];
        hour_sum = {1'b0, i_hour} + (rtccal_pkg::HOUR_W+1)'(c_min);
        c_hour   = hour_sum >= (rtccal_pkg::HOUR_W+1)'(rtccal_pkg::HOUR_PER_DAY);
        n_s1.tod.hour = c_hour
            ? rtccal_pkg::HOUR_W'(hour_sum - (rtccal_pkg::HOUR_W+1)'(rtccal_pkg::HOUR_PER_DAY))
            : hour_sum[rtccal_pkg::HOUR_W-1:0];
        n_s1.days = {1'b0, i_day_count} + rtccal_pkg::DAYS_W'(c_hour);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;
endmodule
`default_nettype wire

// ===== design/rtccal_year.sv =====
// Stages 2 to 4: weekday, year estimate, days before year, one-step year correction.
`default_nettype none
module rtccal_year (
    input  wire logic            i_clk,
    input  wire logic [2:0]      i_en,
    input  wire rtccal_pkg::t_s1 i_s1,
    output rtccal_pkg::t_s4      o_s4
);
    rtccal_pkg::t_s2 r_s2;
    rtccal_pkg::t_s2 n_s2;
    rtccal_pkg::t_s3 r_s3;
    rtccal_pkg::t_s3 n_s3;
    rtccal_pkg::t_s4 r_s4;
    rtccal_pkg::t_s4 n_s4;

    logic [rtccal_pkg::PROD_W-1:0]   prod;
    logic [rtccal_pkg::YOFF_W:0]     q_plus;
    logic [rtccal_pkg::DAYS_W-1:0]   base;
    logic [rtccal_pkg::YOFF_W:0]     q4_plus;
    logic [rtccal_pkg::YOFF_W:0]     q4_plus2;
    logic                            leap_prev;
    logic                            leap_cur;
    logic signed [rtccal_pkg::LEFT_W-1:0] left_fix;

    // stage 2: weekday, and quotient days/365 by reciprocal multiply
    always_comb begin
        prod = rtccal_pkg::PROD_W'(i_s1.days) * rtccal_pkg::PROD_W'(rtccal_pkg::YEAR_RECIP);
        n_s2.days = i_s1.days;
        n_s2.q    = prod[rtccal_pkg::YEAR_SHIFT +: rtccal_pkg::YOFF_W];
        n_s2.wday = rtccal_pkg::mod7(i_s1.days);
        n_s2.tod  = i_s1.tod;
    end

    // stage 3: days before estimated year, leap days from 1970 minus the 2100 exception
    always_comb begin
        q_plus = {1'b0, r_s2.q} + (rtccal_pkg::YOFF_W+1)'(1);
        base = rtccal_pkg::DAYS_W'(r_s2.q) * rtccal_pkg::DAYS_W'(rtccal_pkg::DAYS_PER_YEAR)
             + rtccal_pkg::DAYS_W'(q_plus[rtccal_pkg::YOFF_W:2])
             - rtccal_pkg::DAYS_W'(r_s2.q >= rtccal_pkg::YOFF_W'(rtccal_pkg::Q_2100));
        n_s3.left = $signed({1'b0, r_s2.days}) - $signed({1'b0, base});
        n_s3.q    = r_s2.q;
        n_s3.wday = r_s2.wday;
        n_s3.tod  = r_s2.tod;
    end

    // stage 4: step back one year on overshoot
    always_comb begin
        q4_plus   = {1'b0, r_s3.q} + (rtccal_pkg::YOFF_W+1)'(1);
        q4_plus2  = {1'b0, r_s3.q} + (rtccal_pkg::YOFF_W+1)'(2);
        leap_prev = (q4_plus[1:0] == 2'b00)
                 && (r_s3.q != rtccal_pkg::YOFF_W'(rtccal_pkg::Q_2100));
        leap_cur  = (q4_plus2[1:0] == 2'b00)
                 && (r_s3.q != rtccal_pkg::YOFF_W'(rtccal_pkg::YOFF_2100));
        left_fix  = r_s3.left + $signed(rtccal_pkg::LEFT_W'(rtccal_pkg::DAYS_PER_YEAR))
                  + $signed(rtccal_pkg::LEFT_W'(leap_prev));
        if (r_s3.left[rtccal_pkg::LEFT_W-1]) begin
            n_s4.yoff = r_s3.q - rtccal_pkg::YOFF_W'(1);
            n_s4.left = left_fix[rtccal_pkg::DOY_W-1:0];
            n_s4.leap = leap_prev;
        end else begin
            n_s4.yoff = r_s3.q;
            n_s4.left = r_s3.left[rtccal_pkg::DOY_W-1:0];
            n_s4.leap = leap_cur;
        end
        n_s4.wday = r_s3.wday;
        n_s4.tod  = r_s3.tod;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s2 <= n_s2;
        end
        if (i_en[1]) begin
            r_s3 <= n_s3;
        end
        if (i_en[2]) begin
            r_s4 <= n_s4;
        end
    end

    assign o_s4 = r_s4;
endmodule
`default_nettype wire

// ===== design/rtccal_month.sv =====
// Stage 5: month and day of month from day of year, output register.
`default_nettype none
module rtccal_month (
    input  wire logic            i_clk,
    input  wire logic            i_en,
    input  wire rtccal_pkg::t_s4 i_s4,
    output rtccal_pkg::t_res     o_res
);
    rtccal_pkg::t_res r_res;
    rtccal_pkg::t_res n_res;

    logic [rtccal_pkg::MON_W-1:0] cnt;

    always_comb begin
        cnt = '0;
        for (int i = 1; i < rtccal_pkg::MONTHS; i++) begin
            if (i_s4.left >= rtccal_pkg::month_start(rtccal_pkg::MON_W'(i), i_s4.leap)) begin
                cnt = cnt + rtccal_pkg::MON_W'(1);
            end
        end
        n_res.tod   = i_s4.tod;
        n_res.wday  = i_s4.wday;
        n_res.year  = i_s4.yoff + rtccal_pkg::YEAR_W'(rtccal_pkg::EPOCH_YEAR);
        n_res.doy   = i_s4.left + rtccal_pkg::DOY_W'(1);
        n_res.month = cnt;
        n_res.dom   = rtccal_pkg::DOM_W'(i_s4.left - rtccal_pkg::month_start(cnt, i_s4.leap)
                                         + rtccal_pkg::DOY_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;
endmodule
`default_nettype wire

// ===== design/rtc_day_count_to_calendar.sv =====
// Top level: day-count clock reading to calendar date, five-stage pipeline.
//
//   channel  dir  payload
//   i_in     in   day_count, hour_field, minute_field, second_field
//   o_out    out  hour_out, minute_out, second_out, weekday, year_since_1900,
//                 day_of_year, month_index, day_of_month
//
// One item per cycle while o_out is not stalled; five register stages
// (time carry, reciprocal multiply by 1/365, days before year, year fix, month).
// Each stage holds its own valid bit and loads when empty or when the next stage loads,
// so bubbles close up and a stall on o_out backs up stage by stage to i_in.ready.
// Reset (i_rst_n low, synchronous) clears the valid bits only.
`default_nettype none
module rtc_day_count_to_calendar (
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    rtccal_in_if.sink    i_in,
    rtccal_out_if.source o_out
);
    logic [rtccal_pkg::NSTAGE-1:0] r_vld;
    logic [rtccal_pkg::NSTAGE-1:0] n_vld;
    logic [rtccal_pkg::NSTAGE-1:0] load;

    rtccal_pkg::t_s1  s1;
    rtccal_pkg::t_s4  s4;
    rtccal_pkg::t_res res;

    always_comb begin
        load[rtccal_pkg::NSTAGE-1] = !r_vld[rtccal_pkg::NSTAGE-1] || o_out.ready;
        for (int k = rtccal_pkg::NSTAGE - 2; k >= 0; k--) begin
            load[k] = !r_vld[k] || load[k+1];
        end
        n_vld = r_vld;
        if (load[0]) begin
            n_vld[0] = i_in.valid;
        end
        for (int k = 1; k < rtccal_pkg::NSTAGE; k++) begin
            if (load[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    rtccal_time u_time (
        .i_clk       (i_clk),
        .i_en        (load[0]),
        .i_day_count (i_in.day_count),
        .i_hour      (i_in.hour_field),
        .i_minute    (i_in.minute_field),
        .i_second    (i_in.second_field),
        .o_s1        (s1)
    );

    rtccal_year u_year (
        .i_clk (i_clk),
        .i_en  (load[3:1]),
        .i_s1  (s1),
        .o_s4  (s4)
    );

    rtccal_month u_month (
        .i_clk (i_clk),
        .i_en  (load[4]),
        .i_s4  (s4),
        .o_res (res)
    );

    assign i_in.ready            = load[0];
    assign o_out.valid           = r_vld[rtccal_pkg::NSTAGE-1];
    assign o_out.hour_out        = res.tod.hour;
    assign o_out.minute_out      = res.tod.minute;
    assign o_out.second_out      = res.tod.second;
    assign o_out.weekday         = res.wday;
    assign o_out.year_since_1900 = res.year;
    assign o_out.day_of_year     = res.doy;
    assign o_out.month_index     = res.month;
    assign o_out.day_of_month    = res.dom;
endmodule
`default_nettype wire
